// File: sv/lhp_pkg.sv
// Shared constants, types and helper functions for the latency histogram unit.
`default_nettype none

package lhp_pkg;

    // Histogram geometry
    localparam int NUM_BUCKETS = 64;
    localparam int COUNT_BITS  = 48;
    localparam int BIDX_W      = $clog2(NUM_BUCKETS);

    // Field widths
    localparam int SAMPLE_W  = 64;
    localparam int RANK_W    = 17;
    localparam int OUT_CNT_W = 48;
    localparam int FRAC_W    = 32;

    // Datapath widths for the percentile walk
    localparam int TGT_W   = COUNT_BITS + RANK_W;
    localparam int CUM_W   = COUNT_BITS + BIDX_W;
    localparam int CMP_W   = CUM_W + 16;
    localparam int DELTA_W = COUNT_BITS + 16;

    // Divider geometry: the quotient is a fraction below one in Q32
    localparam int DIV_STEPS = FRAC_W;
    localparam int DIVCNT_W  = $clog2(DIV_STEPS);

    localparam logic [RANK_W-1:0]     RANK_ONE  = RANK_W'(65536);
    localparam logic [COUNT_BITS-1:0] CNT_MAX   = {COUNT_BITS{1'b1}};
    localparam logic [BIDX_W-1:0]     LAST_BUCK = BIDX_W'(NUM_BUCKETS - 1);

    // Request codes
    localparam logic FUNC_RECORD = 1'b0;
    localparam logic FUNC_QUERY  = 1'b1;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_REC_RD,
        S_REC_WR,
        S_Q_MUL,
        S_Q_RD,
        S_Q_CHK,
        S_Q_DIV,
        S_Q_MLO,
        S_Q_MHI,
        S_Q_SUM,
        S_Q_CLAMP,
        S_Q_OUT
    } lhp_state_t;

    // Status reported by the divider
    typedef struct packed {
        logic busy;
        logic done;
    } lhp_div_stat_t;

    // Position of the highest set bit; zero for a zero word.
    function automatic logic [5:0] msb_index(input logic [SAMPLE_W-1:0] v);
        logic [5:0] idx;
        idx = '0;
        for (int k = 0; k < SAMPLE_W; k++)
        begin
            if (v[k])
            begin
                idx = 6'(k);
            end
        end
        return idx;
    endfunction

    // Bucket of a sample, with the top bucket catching every larger sample.
    function automatic logic [BIDX_W-1:0] bucket_of(input logic [SAMPLE_W-1:0] v);
        logic [5:0] msb;
        msb = msb_index(v);
        if ({1'b0, msb} >= 7'(NUM_BUCKETS - 1))
        begin
            return LAST_BUCK;
        end
        return msb[BIDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: sv/lhp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lhp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

// File: sv/lhp_div.sv
// Bit-serial restoring divider that yields the Q32 in-bucket fraction.
`default_nettype none

module lhp_div (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [lhp_pkg::COUNT_BITS-1:0] rem_init,
    input  wire logic [15:0]                    low_bits,
    input  wire logic [lhp_pkg::COUNT_BITS-1:0] divisor,
    output lhp_pkg::lhp_div_stat_t              stat,
    output logic [lhp_pkg::FRAC_W-1:0]          quotient
);

    logic                               busy_reg;
    logic                               done_reg;
    logic [lhp_pkg::DIVCNT_W-1:0]       cnt_reg;
    logic [lhp_pkg::COUNT_BITS-1:0]     rem_reg;
    logic [lhp_pkg::COUNT_BITS-1:0]     dvs_reg;
    logic [lhp_pkg::FRAC_W-1:0]         bits_reg;
    logic [lhp_pkg::FRAC_W-1:0]         quo_reg;

    logic [lhp_pkg::COUNT_BITS:0]       trial;
    logic [lhp_pkg::COUNT_BITS:0]       diff;
    logic                               fits;
    logic [lhp_pkg::COUNT_BITS-1:0]     rem_next;

    // One quotient bit per cycle: shift in a dividend bit, compare, subtract.
    always_comb
    begin
        trial    = {rem_reg, bits_reg[lhp_pkg::FRAC_W-1]};
        diff     = trial - {1'b0, dvs_reg};
        fits     = (trial >= {1'b0, dvs_reg});
        rem_next = fits ? diff[lhp_pkg::COUNT_BITS-1:0] : trial[lhp_pkg::COUNT_BITS-1:0];
    end

    // Control of the iteration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == lhp_pkg::DIVCNT_W'(lhp_pkg::DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder, dividend bits and quotient
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= rem_init;
            dvs_reg  <= divisor;
            bits_reg <= {low_bits, 16'b0};
            quo_reg  <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            bits_reg <= {bits_reg[lhp_pkg::FRAC_W-2:0], 1'b0};
            quo_reg  <= {quo_reg[lhp_pkg::FRAC_W-2:0], fits};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

`default_nettype wire

// File: sv/log2_latency_histogram_percentile_unit.sv
// Latency histogram with power-of-two buckets and interpolated percentile queries.
//
// Requests enter on in_valid/in_ready with func, sample_ns and rank_q16. A record
// request (func 0) files the sample into its log2 bucket, bumps the bucket and the
// total with saturation, and tracks min and max; it produces no result and runs
// through accept, bucket read and bucket write back. A query request (func 1) returns
// one result on out_valid/out_ready: the percentile value plus count, min and max.
// A query walks the bucket RAM one bucket at a time (read, then accumulate and
// compare) up to the bucket that holds the rank, then runs a bit-serial divide for
// the in-bucket fraction and a 32x32 multiply used twice. A query on an empty
// histogram goes straight from accept to the output state.
// in_ready is high only while the sequencer is idle, one request at a time.
// The result sits in an output register, so records are still accepted while a
// query result waits; a query that finishes while the previous result is still
// held waits until the receiver takes it.
// Reset clears per-bucket valid bits so every bucket reads as zero at once, zeroes
// the total and max, sets min to all ones, and drops any pending result.
`default_nettype none

module log2_latency_histogram_percentile_unit (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         func,
    input  wire logic [lhp_pkg::SAMPLE_W-1:0] sample_ns,
    input  wire logic [lhp_pkg::RANK_W-1:0]   rank_q16,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [lhp_pkg::SAMPLE_W-1:0]      result_value,
    output logic [lhp_pkg::OUT_CNT_W-1:0]     count_out,
    output logic [lhp_pkg::SAMPLE_W-1:0]      min_out,
    output logic [lhp_pkg::SAMPLE_W-1:0]      max_out
);

    lhp_pkg::lhp_state_t state_reg;
    lhp_pkg::lhp_state_t state_next;

    // Statistics
    logic [lhp_pkg::NUM_BUCKETS-1:0]  vld_reg;
    logic [lhp_pkg::COUNT_BITS-1:0]   total_reg;
    logic [lhp_pkg::SAMPLE_W-1:0]     lowest_reg;
    logic [lhp_pkg::SAMPLE_W-1:0]     highest_reg;

    // Query datapath
    logic [lhp_pkg::BIDX_W-1:0]       addr_reg;
    logic [lhp_pkg::RANK_W-1:0]       rank_reg;
    logic [lhp_pkg::TGT_W-1:0]        target_reg;
    logic [lhp_pkg::CUM_W-1:0]        cum_reg;
    logic [lhp_pkg::SAMPLE_W-1:0]     lo_reg;
    logic [lhp_pkg::SAMPLE_W-1:0]     span_reg;
    logic [lhp_pkg::FRAC_W-1:0]       frac_reg;
    logic [2*lhp_pkg::FRAC_W-1:0]     plo_reg;
    logic [2*lhp_pkg::FRAC_W-1:0]     phi_reg;
    logic [lhp_pkg::SAMPLE_W-1:0]     vsum_reg;
    logic [lhp_pkg::SAMPLE_W-1:0]     res_reg;

    // Output register
    logic                             out_valid_reg;
    logic [lhp_pkg::SAMPLE_W-1:0]     result_reg;
    logic [lhp_pkg::OUT_CNT_W-1:0]    count_reg;
    logic [lhp_pkg::SAMPLE_W-1:0]     min_reg;
    logic [lhp_pkg::SAMPLE_W-1:0]     max_reg;

    // Combinational signals
    logic                             in_acc;
    logic                             out_free;
    logic                             ram_we;
    logic                             div_start;
    logic                             load_out;
    logic [lhp_pkg::COUNT_BITS-1:0]   ram_rdata;
    logic [lhp_pkg::COUNT_BITS-1:0]   n_val;
    logic [lhp_pkg::COUNT_BITS-1:0]   cnt_inc;
    logic [lhp_pkg::CUM_W-1:0]        next_sum;
    logic [lhp_pkg::CMP_W-1:0]        cum_sh;
    logic [lhp_pkg::CMP_W-1:0]        delta_full;
    logic [lhp_pkg::DELTA_W-1:0]      delta;
    logic                             pass;
    logic                             last;
    logic [lhp_pkg::SAMPLE_W-1:0]     lo_val;
    logic [lhp_pkg::SAMPLE_W-1:0]     hi_val;
    logic [lhp_pkg::SAMPLE_W-1:0]     span_val;
    logic [lhp_pkg::FRAC_W-1:0]       mul_b;
    logic [2*lhp_pkg::FRAC_W-1:0]     mul_p;
    logic [lhp_pkg::SAMPLE_W-1:0]     v_low;
    logic [lhp_pkg::SAMPLE_W-1:0]     v_clamp;
    logic [lhp_pkg::SAMPLE_W-1:0]     total_wide;
    logic [lhp_pkg::RANK_W-1:0]       rank_sat;
    lhp_pkg::lhp_div_stat_t           div_stat;
    logic [lhp_pkg::FRAC_W-1:0]       div_q;

    assign in_ready = (state_reg == lhp_pkg::S_IDLE);
    assign in_acc   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // Bucket count store
    lhp_ram #(
        .WIDTH (lhp_pkg::COUNT_BITS),
        .DEPTH (lhp_pkg::NUM_BUCKETS)
    ) u_buckets (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (cnt_inc),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    // Fraction divider
    lhp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .rem_init (delta[lhp_pkg::DELTA_W-1:16]),
        .low_bits (delta[15:0]),
        .divisor  (n_val),
        .stat     (div_stat),
        .quotient (div_q)
    );

    // Bucket datapath: count read back, accumulate, compare against the target
    always_comb
    begin
        n_val      = vld_reg[addr_reg] ? ram_rdata : '0;
        cnt_inc    = (n_val == lhp_pkg::CNT_MAX) ? n_val : n_val + 1'b1;
        next_sum   = cum_reg + lhp_pkg::CUM_W'(n_val);
        cum_sh     = {cum_reg, 16'b0};
        pass       = ({next_sum, 16'b0} <= lhp_pkg::CMP_W'(target_reg));
        delta_full = lhp_pkg::CMP_W'(target_reg) - cum_sh;
        delta      = delta_full[lhp_pkg::DELTA_W-1:0];
        last       = (addr_reg == lhp_pkg::LAST_BUCK);
    end

    // Bucket edges of the current bucket
    always_comb
    begin
        lo_val   = (addr_reg == '0) ? '0 : (lhp_pkg::SAMPLE_W'(1) << addr_reg);
        hi_val   = last ? highest_reg : (lhp_pkg::SAMPLE_W'(2) << addr_reg);
        span_val = (hi_val > lo_val) ? hi_val - lo_val : '0;
    end

    // Shared 32x32 multiplier for the two halves of the span
    always_comb
    begin
        mul_b = (state_reg == lhp_pkg::S_Q_MHI) ? span_reg[63:32] : span_reg[31:0];
        mul_p = (2 * lhp_pkg::FRAC_W)'(frac_reg) * (2 * lhp_pkg::FRAC_W)'(mul_b);
    end

    // Clamp to the observed range, widen the total and saturate the rank at one
    always_comb
    begin
        v_low      = (vsum_reg < lowest_reg) ? lowest_reg : vsum_reg;
        v_clamp    = (v_low > highest_reg) ? highest_reg : v_low;
        total_wide = lhp_pkg::SAMPLE_W'(total_reg);
        rank_sat   = (rank_q16 > lhp_pkg::RANK_ONE) ? lhp_pkg::RANK_ONE : rank_q16;
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lhp_pkg::S_IDLE:
            begin
                if (in_acc)
                begin
                    if (func == lhp_pkg::FUNC_RECORD)
                    begin
                        state_next = lhp_pkg::S_REC_RD;
                    end
                    else if (total_reg == '0)
                    begin
                        state_next = lhp_pkg::S_Q_OUT;
                    end
                    else
                    begin
                        state_next = lhp_pkg::S_Q_MUL;
                    end
                end
            end
            lhp_pkg::S_REC_RD:  state_next = lhp_pkg::S_REC_WR;
            lhp_pkg::S_REC_WR:  state_next = lhp_pkg::S_IDLE;
            lhp_pkg::S_Q_MUL:   state_next = lhp_pkg::S_Q_RD;
            lhp_pkg::S_Q_RD:    state_next = lhp_pkg::S_Q_CHK;
            lhp_pkg::S_Q_CHK:
            begin
                if (!pass)
                begin
                    state_next = lhp_pkg::S_Q_DIV;
                end
                else if (last)
                begin
                    state_next = lhp_pkg::S_Q_OUT;
                end
                else
                begin
                    state_next = lhp_pkg::S_Q_RD;
                end
            end
            lhp_pkg::S_Q_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = lhp_pkg::S_Q_MLO;
                end
            end
            lhp_pkg::S_Q_MLO:   state_next = lhp_pkg::S_Q_MHI;
            lhp_pkg::S_Q_MHI:   state_next = lhp_pkg::S_Q_SUM;
            lhp_pkg::S_Q_SUM:   state_next = lhp_pkg::S_Q_CLAMP;
            lhp_pkg::S_Q_CLAMP: state_next = lhp_pkg::S_Q_OUT;
            lhp_pkg::S_Q_OUT:
            begin
                if (out_free)
                begin
                    state_next = lhp_pkg::S_IDLE;
                end
            end
            default:            state_next = lhp_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        ram_we    = 1'b0;
        div_start = 1'b0;
        load_out  = 1'b0;
        unique case (state_reg)
            lhp_pkg::S_REC_WR: ram_we    = 1'b1;
            lhp_pkg::S_Q_CHK:  div_start = !pass;
            lhp_pkg::S_Q_OUT:  load_out  = out_free;
            default:
            begin
                ram_we    = 1'b0;
                div_start = 1'b0;
                load_out  = 1'b0;
            end
        endcase
    end

    // State, statistics and output handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lhp_pkg::S_IDLE;
            vld_reg       <= '0;
            total_reg     <= '0;
            lowest_reg    <= '1;
            highest_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_acc && (func == lhp_pkg::FUNC_RECORD))
            begin
                if (total_reg != lhp_pkg::CNT_MAX)
                begin
                    total_reg <= total_reg + 1'b1;
                end
                if (sample_ns < lowest_reg)
                begin
                    lowest_reg <= sample_ns;
                end
                if (sample_ns > highest_reg)
                begin
                    highest_reg <= sample_ns;
                end
            end
            if (ram_we)
            begin
                vld_reg[addr_reg] <= 1'b1;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Query payload registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            lhp_pkg::S_IDLE:
            begin
                if (in_acc)
                begin
                    addr_reg <= (func == lhp_pkg::FUNC_RECORD) ?
                                lhp_pkg::bucket_of(sample_ns) : '0;
                    rank_reg <= rank_sat;
                    cum_reg  <= '0;
                    res_reg  <= '0;
                end
            end
            lhp_pkg::S_Q_MUL:
            begin
                target_reg <= lhp_pkg::TGT_W'(total_reg) * lhp_pkg::TGT_W'(rank_reg);
            end
            lhp_pkg::S_Q_CHK:
            begin
                if (pass)
                begin
                    cum_reg <= next_sum;
                    if (last)
                    begin
                        res_reg <= highest_reg;
                    end
                    else
                    begin
                        addr_reg <= addr_reg + 1'b1;
                    end
                end
                else
                begin
                    lo_reg   <= lo_val;
                    span_reg <= span_val;
                end
            end
            lhp_pkg::S_Q_DIV:
            begin
                if (div_stat.done)
                begin
                    frac_reg <= div_q;
                end
            end
            lhp_pkg::S_Q_MLO:   plo_reg  <= mul_p;
            lhp_pkg::S_Q_MHI:   phi_reg  <= mul_p;
            lhp_pkg::S_Q_SUM:
            begin
                vsum_reg <= lo_reg + phi_reg + {32'b0, plo_reg[63:32]};
            end
            lhp_pkg::S_Q_CLAMP: res_reg  <= v_clamp;
            default:
            begin
                res_reg <= res_reg;
            end
        endcase
        if (load_out)
        begin
            result_reg <= res_reg;
            count_reg  <= total_wide[lhp_pkg::OUT_CNT_W-1:0];
            min_reg    <= lowest_reg;
            max_reg    <= highest_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_value = result_reg;
    assign count_out    = count_reg;
    assign min_out      = min_reg;
    assign max_out      = max_reg;

    // A new result appears only after the sequencer reached its output state.
    a_rise_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == lhp_pkg::S_Q_OUT))
        else $error("result raised outside the output state");

    // The divider finishes only while the sequencer waits for it.
    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == lhp_pkg::S_Q_DIV))
        else $error("divider finished outside the divide state");

    // A nonempty histogram answers within the observed range.
    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (count_reg != '0)) |->
            ((result_reg >= min_reg) && (result_reg <= max_reg)))
        else $error("percentile outside the observed range");

    // With no samples, min and max keep their empty values.
    a_empty_stats: assert property (@(posedge clk) disable iff (!rst_n)
        (total_reg == '0) |-> ((lowest_reg == '1) && (highest_reg == '0)))
        else $error("min or max changed with no samples recorded");

endmodule

`default_nettype wire

// File: dv/log2_latency_histogram_percentile_unit_test.sv
// Self-checking testbench for the log2 latency histogram and percentile unit.
module log2_latency_histogram_percentile_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 200;
    localparam int RANDOM_ITEMS    = 1300;
    localparam int REPORT_LIMIT    = 10;

    // One percentile answer as the block reports it
    typedef struct {
        logic [lhp_pkg::SAMPLE_W-1:0]  value;
        logic [lhp_pkg::OUT_CNT_W-1:0] count;
        logic [lhp_pkg::SAMPLE_W-1:0]  lowest;
        logic [lhp_pkg::SAMPLE_W-1:0]  highest;
    } pct_answer_t;

    logic                           clk;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    logic                           func      = lhp_pkg::FUNC_RECORD;
    logic [lhp_pkg::SAMPLE_W-1:0]   sample_ns = '0;
    logic [lhp_pkg::RANK_W-1:0]     rank_q16  = '0;
    logic                           out_ready = 1'b0;
    logic                           in_ready;
    logic                           out_valid;
    logic [lhp_pkg::SAMPLE_W-1:0]   result_value;
    logic [lhp_pkg::OUT_CNT_W-1:0]  count_out;
    logic [lhp_pkg::SAMPLE_W-1:0]   min_out;
    logic [lhp_pkg::SAMPLE_W-1:0]   max_out;

    // Histogram shadow state
    logic [lhp_pkg::COUNT_BITS-1:0] bin_count [lhp_pkg::NUM_BUCKETS];
    logic [lhp_pkg::COUNT_BITS-1:0] samples_total;
    logic [lhp_pkg::SAMPLE_W-1:0]   smallest_sample;
    logic [lhp_pkg::SAMPLE_W-1:0]   largest_sample;

    pct_answer_t pending_answers [$];
    int          mismatch_count  = 0;
    int          quiet_cycles    = 0;
    int          burst_left      = 0;
    bit          hold_off_pending = 1'b0;

    log2_latency_histogram_percentile_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .sample_ns    (sample_ns),
        .rank_q16     (rank_q16),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_value (result_value),
        .count_out    (count_out),
        .min_out      (min_out),
        .max_out      (max_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Bucket index: highest set bit, zero for a zero sample, top bucket catches the rest.
    function automatic int bucket_index(input logic [lhp_pkg::SAMPLE_W-1:0] v);
        int idx;
        idx = 0;
        for (int k = lhp_pkg::SAMPLE_W - 1; k >= 0; k--)
        begin
            if (v[k])
            begin
                idx = k;
                break;
            end
        end
        if (idx > lhp_pkg::NUM_BUCKETS - 1)
        begin
            idx = lhp_pkg::NUM_BUCKETS - 1;
        end
        return idx;
    endfunction

    function automatic void clear_histogram_model();
        for (int i = 0; i < lhp_pkg::NUM_BUCKETS; i++)
        begin
            bin_count[i] = '0;
        end
        samples_total   = '0;
        smallest_sample = '1;
        largest_sample  = '0;
    endfunction

    function automatic void record_sample(input logic [lhp_pkg::SAMPLE_W-1:0] s);
        int b;
        b = bucket_index(s);
        if (bin_count[b] != lhp_pkg::CNT_MAX)
        begin
            bin_count[b] = bin_count[b] + 1'b1;
        end
        if (samples_total != lhp_pkg::CNT_MAX)
        begin
            samples_total = samples_total + 1'b1;
        end
        if (s < smallest_sample)
        begin
            smallest_sample = s;
        end
        if (s > largest_sample)
        begin
            largest_sample = s;
        end
    endfunction

    // Walk the buckets to the one that holds the target rank and interpolate inside it.
    function automatic logic [lhp_pkg::SAMPLE_W-1:0] percentile_value(
        input logic [lhp_pkg::RANK_W-1:0] rank_in);
        logic [127:0]                 target;
        logic [127:0]                 cum;
        logic [127:0]                 next_cum;
        logic [127:0]                 delta;
        logic [127:0]                 quot;
        logic [127:0]                 prod;
        logic [lhp_pkg::SAMPLE_W-1:0] lo;
        logic [lhp_pkg::SAMPLE_W-1:0] hi;
        logic [lhp_pkg::SAMPLE_W-1:0] span;
        logic [lhp_pkg::SAMPLE_W-1:0] v;
        logic [lhp_pkg::RANK_W-1:0]   rank;
        if (samples_total == 0)
        begin
            return '0;
        end
        rank = (rank_in > lhp_pkg::RANK_ONE) ? lhp_pkg::RANK_ONE : rank_in;
        target = 128'(samples_total) * 128'(rank);
        cum = '0;
        for (int i = 0; i < lhp_pkg::NUM_BUCKETS; i++)
        begin
            if (bin_count[i] == 0)
            begin
                continue;
            end
            next_cum = cum + 128'(bin_count[i]);
            if ((next_cum << 16) <= target)
            begin
                cum = next_cum;
                continue;
            end
            lo = (i == 0) ? '0 : (64'd1 << i);
            hi = (i == lhp_pkg::NUM_BUCKETS - 1 || i + 1 > lhp_pkg::SAMPLE_W - 1) ?
                 largest_sample : (64'd1 << (i + 1));
            span = (hi > lo) ? hi - lo : '0;
            delta = target - (cum << 16);
            quot = (delta << 16) / 128'(bin_count[i]);
            prod = 128'(quot[63:0]) * 128'(span);
            v = lo + prod[95:32];
            if (v < smallest_sample)
            begin
                v = smallest_sample;
            end
            if (v > largest_sample)
            begin
                v = largest_sample;
            end
            return v;
        end
        return largest_sample;
    endfunction

    function automatic pct_answer_t query_answer(input logic [lhp_pkg::RANK_W-1:0] rank);
        pct_answer_t a;
        a.value   = percentile_value(rank);
        a.count   = samples_total[lhp_pkg::OUT_CNT_W-1:0];
        a.lowest  = smallest_sample;
        a.highest = largest_sample;
        return a;
    endfunction

    function automatic logic [lhp_pkg::SAMPLE_W-1:0] random_word();
        return {$urandom, $urandom};
    endfunction

    // Samples spread over every bucket, with zero, all ones and raw words mixed in.
    function automatic logic [lhp_pkg::SAMPLE_W-1:0] random_latency();
        int sel;
        int b;
        sel = $urandom_range(0, 19);
        if (sel == 0)
        begin
            return '0;
        end
        if (sel == 1)
        begin
            return '1;
        end
        if (sel == 2)
        begin
            return random_word();
        end
        b = $urandom_range(0, lhp_pkg::SAMPLE_W - 1);
        return (random_word() >> (lhp_pkg::SAMPLE_W - 1 - b)) | (64'd1 << b);
    endfunction

    function automatic logic [lhp_pkg::RANK_W-1:0] random_rank();
        int sel;
        sel = $urandom_range(0, 11);
        if (sel == 0)
        begin
            return '0;
        end
        if (sel == 1)
        begin
            return lhp_pkg::RANK_ONE;
        end
        if (sel == 2)
        begin
            return lhp_pkg::RANK_W'($urandom_range(65537, 131071));
        end
        return lhp_pkg::RANK_W'($urandom_range(0, 65536));
    endfunction

    // Offer one request, idling between bursts, and update the shadow state on acceptance.
    task automatic send_request(input logic f, input logic [lhp_pkg::SAMPLE_W-1:0] s,
                                input logic [lhp_pkg::RANK_W-1:0] r);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        in_valid  <= 1'b1;
        func      <= f;
        sample_ns <= s;
        rank_q16  <= r;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        if (f == lhp_pkg::FUNC_QUERY)
        begin
            pending_answers.push_back(query_answer(r));
        end
        else
        begin
            record_sample(s);
        end
    endtask

    task automatic send_record(input logic [lhp_pkg::SAMPLE_W-1:0] s);
        send_request(lhp_pkg::FUNC_RECORD, s, lhp_pkg::RANK_W'($urandom_range(0, 131071)));
    endtask

    task automatic send_query(input logic [lhp_pkg::RANK_W-1:0] r);
        send_request(lhp_pkg::FUNC_QUERY, random_word(), r);
    endtask

    // Queries before any sample must answer zero with the reset min and max.
    task automatic test_empty_histogram();
        send_query('0);
        send_query(lhp_pkg::RANK_ONE);
        send_query('1);
    endtask

    // Two samples in neighboring buckets: interpolation and clamping to min and max.
    task automatic test_interpolation_and_clamp();
        send_record(64'd1000);
        send_record(64'd1500);
        send_query('0);
        send_query(lhp_pkg::RANK_W'(32768));
        send_query(lhp_pkg::RANK_W'(49152));
    endtask

    // Extreme samples, full rank, rank past every bucket and rank above one.
    task automatic test_extreme_samples();
        send_record('0);
        send_record(64'd1);
        send_record(64'h8000_0000_0000_0000);
        send_record('1);
        send_record(64'h7FFF_FFFF_FFFF_FFFF);
        send_query('0);
        send_query(lhp_pkg::RANK_W'(1));
        send_query(lhp_pkg::RANK_W'(32768));
        send_query(lhp_pkg::RANK_W'(65535));
        send_query(lhp_pkg::RANK_ONE);
        send_query(lhp_pkg::RANK_W'(65537));
        send_query('1);
    endtask

    // Receiver holds off while queries keep coming, so the result register fills up.
    task automatic test_output_backpressure();
        hold_off_pending = 1'b1;
        burst_left = 60;
        for (int i = 0; i < 24; i++)
        begin
            if (i % 4 == 0)
            begin
                send_query(random_rank());
            end
            else
            begin
                send_record(random_latency());
            end
        end
    endtask

    // Long mixed stream: mostly records with occasional queries.
    task automatic test_random_traffic();
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                send_query(random_rank());
            end
            else
            begin
                send_record(random_latency());
            end
        end
    endtask

    // Receiver: random stall segments, plus one long hold-off on request.
    initial
    begin
        int seg_left;
        int mode;
        int hold_left;
        seg_left  = 0;
        mode      = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off_pending)
            begin
                hold_off_pending = 1'b0;
                hold_left = HOLD_OFF_CYCLES;
                out_ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    mode = $urandom_range(0, 2);
                    seg_left = $urandom_range(1, 50);
                end
                seg_left--;
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= ($urandom_range(0, 1) == 0);
                    default: out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Compare each accepted result with the oldest outstanding answer.
    always @(posedge clk)
    begin
        pct_answer_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_answers.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                begin
                    $display("unexpected result: value=%h count=%h min=%h max=%h",
                             result_value, count_out, min_out, max_out);
                end
            end
            else
            begin
                want = pending_answers.pop_front();
                if (result_value !== want.value || count_out !== want.count ||
                    min_out !== want.lowest || max_out !== want.highest)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                    begin
                        $display("mismatch: value exp %h got %h, count exp %h got %h",
                                 want.value, result_value, want.count, count_out);
                        $display("          min exp %h got %h, max exp %h got %h",
                                 want.lowest, min_out, want.highest, max_out);
                    end
                end
            end
        end
    end

    // Watchdog: end the run if no request or result moves for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        clear_histogram_model();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_histogram();
        test_interpolation_and_clamp();
        test_extreme_samples();
        test_output_backpressure();
        test_random_traffic();

        in_valid <= 1'b0;
        while (pending_answers.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_answers.size() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: log2_latency_histogram_percentile_unit.f
sv/lhp_pkg.sv
sv/lhp_ram.sv
sv/lhp_div.sv
sv/log2_latency_histogram_percentile_unit.sv
dv/log2_latency_histogram_percentile_unit_test.sv
